// ----- rtl/core/size_class_block_allocator_macros.svh -----
// Assertion macros shared by the size class block allocator RTL.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons must hold too.
`define SCBA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("size class allocator: same-cycle check failed");
// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define SCBA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("size class allocator: next-cycle check failed");
`else
`define SCBA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/scba_pkg.sv -----
// Shared types, constants and class geometry functions for the size class allocator.
`default_nettype none

package scba_pkg;

  localparam int unsigned MAX_CLASSES     = 10;
  localparam int unsigned NUM_CLASSES_DEF = 10;
  localparam int unsigned MIN_ALIGN_DEF   = 16;

  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned ADDR_W      = 23;
  localparam int unsigned OFFSET_BITS = 19;
  localparam int unsigned OFFSET_SPAN = 1 << OFFSET_BITS;
  localparam int unsigned CLS_W       = ADDR_W - OFFSET_BITS;
  localparam int unsigned CLS_N       = 1 << CLS_W;
  localparam int unsigned MAX_BLOCKS  = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned SZ_W        = 13;
  localparam int unsigned SPAN_W      = OFFSET_BITS + 1;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 30;
  localparam int unsigned PROD1_W     = OFFSET_BITS + RECIP_W;
  localparam int unsigned QUOT_W      = PROD1_W - RECIP_SHIFT;
  localparam int unsigned PROD2_W     = QUOT_W + SZ_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOMEM = 2'd2,
    ST_STATE = 2'd3
  } scba_status_e;

  // One classified request waiting for the stack engine.
  typedef struct packed {
    logic               is_free;
    scba_status_e       status;
    logic [CLS_W-1:0]   cls;
    logic [IDX_W-1:0]   idx;
  } scba_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scba_qstat_t;

  // Nominal byte size of each class; unused codes return the smallest size.
  function automatic int unsigned class_bytes_f(int unsigned c);
    int unsigned b;
    case (c)
      0:       b = 8;
      1:       b = 16;
      2:       b = 32;
      3:       b = 64;
      4:       b = 128;
      5:       b = 256;
      6:       b = 512;
      7:       b = 1024;
      8:       b = 2048;
      9:       b = 4096;
      default: b = 8;
    endcase
    return b;
  endfunction

  function automatic int unsigned pool_blocks_f(int unsigned bytes);
    int unsigned n;
    if (bytes <= 32)       n = 1024;
    else if (bytes <= 128) n = 512;
    else if (bytes <= 512) n = 256;
    else                   n = 128;
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scba_front.sv -----
// Request classifier: picks the class, checks free addresses and derives the block index.
`default_nettype none

module scba_front import scba_pkg::*; #(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int unsigned MIN_ALIGN   = MIN_ALIGN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              op_i,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [ADDR_W-1:0] block_addr_i,
  input  wire scba_qstat_t       q_stat_i,
  output logic                   q_push_o,
  output scba_req_t              q_entry_o
);

  localparam int unsigned EFF = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [SZ_W-1:0]    sz_tab    [CLS_N];
  logic [SPAN_W-1:0]  span_tab  [CLS_N];
  logic [RECIP_W-1:0] recip_tab [CLS_N];
  logic [CLS_N-1:0]   valid_tab;

  for (genvar g = 0; g < CLS_N; g++) begin : g_geom
    localparam int unsigned CB    = class_bytes_f(g);
    localparam int unsigned SZ    = ((CB + MIN_ALIGN - 1) / MIN_ALIGN) * MIN_ALIGN;
    localparam int unsigned NCAP  = OFFSET_SPAN / SZ;
    localparam int unsigned NPOOL = pool_blocks_f(CB);
    localparam int unsigned NB    = (NPOOL < NCAP) ? NPOOL : NCAP;
    localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + SZ - 1) / SZ;
    assign sz_tab[g]    = SZ_W'(SZ);
    assign span_tab[g]  = SPAN_W'(SZ * NB);
    assign recip_tab[g] = RECIP_W'(RECIP);
    assign valid_tab[g] = (g < EFF);
  end

  logic [1:0]          state_q, state_d;
  logic                op_q, op_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [CLS_W-1:0]    cls_q, cls_d;
  scba_status_e        st_q, st_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [PROD2_W-1:0]  prod2_q, prod2_d;

  logic                accept;
  logic                can_take;
  logic [CLS_W-1:0]    free_cls;
  logic [OFFSET_BITS-1:0] off;
  logic [PROD1_W-1:0]  prod1;
  logic [CLS_W-1:0]    alloc_cls;
  logic                alloc_ok;
  logic                misaligned;

  assign can_take = (state_q == F_IDLE) || ((state_q == F_PUSH) && !q_stat_i.full);
  assign busy     = !can_take;
  assign accept   = start && can_take;

  assign free_cls = addr_q[ADDR_W-1:OFFSET_BITS];
  assign off      = addr_q[OFFSET_BITS-1:0];
  // Exact quotient off / size by a rounded-up reciprocal; exact for 19-bit offsets.
  assign prod1    = PROD1_W'(off) * PROD1_W'(recip_tab[free_cls]);

  // Smallest class that holds the request; the highest hit is overwritten by lower ones.
  always_comb begin
    alloc_cls = '0;
    alloc_ok  = 1'b0;
    for (int i = EFF - 1; i >= 0; i--) begin
      if (size_q <= SIZE_W'(class_bytes_f(i))) begin
        alloc_cls = CLS_W'(i);
        alloc_ok  = 1'b1;
      end
    end
    if (size_q == '0) alloc_ok = 1'b0;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    size_d  = size_q;
    addr_d  = addr_q;
    cls_d   = cls_q;
    st_d    = st_q;
    quot_d  = quot_q;
    prod2_d = prod2_q;
    case (state_q)
      F_IDLE: begin
        state_d = F_IDLE;
      end
      F_CALC: begin
        if (op_q == OP_ALLOC) begin
          cls_d = alloc_cls;
          st_d  = alloc_ok ? ST_OK : ST_INVAL;
        end else begin
          cls_d = free_cls;
          st_d  = (valid_tab[free_cls] && (SPAN_W'(off) < span_tab[free_cls])) ?
                  ST_OK : ST_INVAL;
        end
        quot_d  = prod1[PROD1_W-1:RECIP_SHIFT];
        state_d = F_MUL;
      end
      F_MUL: begin
        prod2_d = PROD2_W'(quot_q) * PROD2_W'(sz_tab[cls_q]);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat_i.full) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
    if (accept) begin
      op_d    = op_i;
      size_d  = req_size_i;
      addr_d  = block_addr_i;
      state_d = F_CALC;
    end
  end

  assign misaligned = (op_q == OP_FREE) && (prod2_q != PROD2_W'(off));

  assign q_push_o          = (state_q == F_PUSH) && !q_stat_i.full;
  assign q_entry_o.is_free = op_q;
  assign q_entry_o.status  = ((st_q == ST_OK) && misaligned) ? ST_INVAL : st_q;
  assign q_entry_o.cls     = cls_q;
  assign q_entry_o.idx     = quot_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    size_q  <= size_d;
    addr_q  <= addr_d;
    cls_q   <= cls_d;
    st_q    <= st_d;
    quot_q  <= quot_d;
    prod2_q <= prod2_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/scba_queue.sv -----
// Two-entry request queue between the classifier and the stack engine.
`default_nettype none

module scba_queue import scba_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire scba_req_t entry_i,
  input  wire logic      pop_i,
  output scba_req_t      head_o,
  output scba_qstat_t    stat_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = PTR_W + 1;

  scba_req_t          slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0]  count_q;

  assign stat_o.full  = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

// ----- rtl/core/scba_back.sv -----
// Stack engine: per-class free counts, the shared free-index memory and the result register.
`default_nettype none

module scba_back import scba_pkg::*; #(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int unsigned MIN_ALIGN   = MIN_ALIGN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scba_req_t         head_i,
  input  wire scba_qstat_t       q_stat_i,
  output logic                   pop_o,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [ADDR_W-1:0]      alloc_addr_o
);

  localparam int unsigned EFF    = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;
  localparam int unsigned CIDX_W = (EFF > 1) ? $clog2(EFF) : 1;
  localparam int unsigned NCLS   = 1 << CIDX_W;
  localparam int unsigned MEM_DEPTH = EFF * MAX_BLOCKS;
  localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);

  localparam logic B_IDLE  = 1'b0;
  localparam logic B_ALLOC = 1'b1;

  logic [SZ_W-1:0]  sz_tab [NCLS];
  logic [CNT_W-1:0] n_tab  [NCLS];
  logic [CNT_W-1:0] cnt_q  [NCLS];
  logic [CNT_W-1:0] min_q  [NCLS];
  logic [NCLS-1:0]  cnt_we;
  logic [NCLS-1:0]  min_we;
  logic [CNT_W-1:0] cnt_d;

  // A stack entry below the lowest count ever reached was never written, so
  // the engine uses that entry's own position instead of the memory content.
  for (genvar g = 0; g < NCLS; g++) begin : g_cls
    localparam int unsigned CB    = class_bytes_f(g);
    localparam int unsigned SZ    = ((CB + MIN_ALIGN - 1) / MIN_ALIGN) * MIN_ALIGN;
    localparam int unsigned NCAP  = OFFSET_SPAN / SZ;
    localparam int unsigned NPOOL = pool_blocks_f(CB);
    localparam int unsigned NB    = (g < EFF) ? ((NPOOL < NCAP) ? NPOOL : NCAP) : 0;
    assign sz_tab[g] = SZ_W'(SZ);
    assign n_tab[g]  = CNT_W'(NB);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[g] <= CNT_W'(NB);
        min_q[g] <= CNT_W'(NB);
      end else begin
        if (cnt_we[g]) cnt_q[g] <= cnt_d;
        if (min_we[g]) min_q[g] <= cnt_d;
      end
    end
  end

  logic [IDX_W-1:0]  stack_mem [MEM_DEPTH];
  logic [IDX_W-1:0]  rd_data_q;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [IDX_W-1:0]  mem_wd;

  logic              state_q, state_d;
  logic              done_q, done_d;
  scba_status_e      status_q, status_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic              fresh_q, fresh_d;
  logic [IDX_W-1:0]  fresh_idx_q, fresh_idx_d;

  logic [CIDX_W-1:0] head_cls;
  logic [CNT_W-1:0]  cur_cnt, cur_min, cur_n;
  logic [IDX_W-1:0]  pop_idx;
  logic [IDX_W+SZ_W-1:0] offset_prod;

  assign head_cls = head_i.cls[CIDX_W-1:0];
  assign cur_cnt  = cnt_q[head_cls];
  assign cur_min  = min_q[head_cls];
  assign cur_n    = n_tab[head_cls];
  assign pop_idx  = fresh_q ? fresh_idx_q : rd_data_q;
  assign offset_prod = (IDX_W+SZ_W)'(pop_idx) * (IDX_W+SZ_W)'(sz_tab[cls_q[CIDX_W-1:0]]);

  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    status_d    = ST_OK;
    addr_d      = '0;
    cls_d       = cls_q;
    fresh_d     = fresh_q;
    fresh_idx_d = fresh_idx_q;
    pop_o       = 1'b0;
    cnt_we      = '0;
    min_we      = '0;
    cnt_d       = cur_cnt;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wa      = MEM_AW'({head_i.cls, cur_cnt[IDX_W-1:0]});
    mem_ra      = MEM_AW'({head_i.cls, cur_cnt[IDX_W-1:0] - 1'b1});
    mem_wd      = head_i.idx;
    case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (head_i.status != ST_OK) begin
            done_d   = 1'b1;
            status_d = head_i.status;
          end else if (head_i.is_free == OP_ALLOC) begin
            if (cur_cnt == '0) begin
              done_d   = 1'b1;
              status_d = ST_NOMEM;
            end else begin
              cnt_d              = cur_cnt - 1'b1;
              cnt_we[head_cls]   = 1'b1;
              mem_re             = 1'b1;
              fresh_d            = (cnt_d < cur_min);
              min_we[head_cls]   = (cnt_d < cur_min);
              fresh_idx_d        = cnt_d[IDX_W-1:0];
              cls_d              = head_i.cls;
              state_d            = B_ALLOC;
            end
          end else begin
            if (cur_cnt >= cur_n) begin
              done_d   = 1'b1;
              status_d = ST_STATE;
            end else begin
              mem_we           = 1'b1;
              cnt_d            = cur_cnt + 1'b1;
              cnt_we[head_cls] = 1'b1;
              done_d           = 1'b1;
              status_d         = ST_OK;
            end
          end
        end
      end
      B_ALLOC: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        addr_d   = {cls_q, offset_prod[OFFSET_BITS-1:0]};
        state_d  = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= stack_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    addr_q      <= addr_d;
    cls_q       <= cls_d;
    fresh_q     <= fresh_d;
    fresh_idx_q <= fresh_idx_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign alloc_addr_o = addr_q;

endmodule

`default_nettype wire

// ----- rtl/core/size_class_block_allocator.sv -----
// Top level of the size class block allocator: classifier, request queue and stack engine.
// Path: the classifier picks the class and quotient, runs the check multiply and hands the
//   request to the queue; the stack engine then reports, with an address step for allocations.
// Throughput: the classifier takes a new request while handing the last one to the queue,
//   unless the queue is full, so classification of one request overlaps the stack engine.
// Reset: every class stack starts full with indices 0..n-1; no clearing pass is run.
`default_nettype none
`include "size_class_block_allocator_macros.svh"

module size_class_block_allocator import scba_pkg::*; #(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int unsigned MIN_ALIGN   = MIN_ALIGN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              op_i,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [ADDR_W-1:0] block_addr_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [ADDR_W-1:0]      alloc_addr_o
);

  // A beat is taken whenever start is high and busy is low. The classifier
  // chooses the class and forms the quotient of the free offset by the block
  // size in its calc state, multiplies it back for the alignment check in its
  // mul state, and hands the request to the queue in its push state. It takes
  // the next beat in that push state, as long as the queue has room.
  scba_qstat_t q_stat;
  scba_req_t   q_entry;
  scba_req_t   q_head;
  logic        q_push;
  logic        q_pop;

  scba_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .MIN_ALIGN   (MIN_ALIGN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .req_size_i   (req_size_i),
    .block_addr_i (block_addr_i),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  // The queue lets the classifier finish a request while the stack engine is
  // still producing the previous result, and vice versa.
  scba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // The stack engine pops or pushes one block index per successful request. An
  // allocation reads the stack memory and builds the address in the following
  // cycle; a free writes the memory and reports in the same step. Every
  // result beat is held on the outputs for exactly one cycle.
  scba_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .MIN_ALIGN   (MIN_ALIGN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .q_stat_i     (q_stat),
    .pop_o        (q_pop),
    .done_o       (done_o),
    .status_o     (status_o),
    .alloc_addr_o (alloc_addr_o)
  );

  // Any result other than success carries a zero address.
  `SCBA_ASSERT_IMPL(a_fail_addr_zero, clk_i, rst_ni, done_o && (status_o != ST_OK), alloc_addr_o == '0)
  // The classifier never hands a request to a full queue.
  `SCBA_ASSERT_IMPL(a_queue_no_overflow, clk_i, rst_ni, q_push, !q_stat.full)
  // The stack engine never takes from an empty queue.
  `SCBA_ASSERT_IMPL(a_queue_no_underflow, clk_i, rst_ni, q_pop, !q_stat.empty)
  // An accepted beat keeps the classifier busy in the following cycle.
  `SCBA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)

endmodule

`default_nettype wire

// ----- bench/allocator_checker.sv -----
// Checker for the size class block allocator: predicts every grant and compares each result.
`default_nettype none

module allocator_checker import scba_pkg::*; #(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int unsigned MIN_ALIGN   = MIN_ALIGN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic              op_i,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [ADDR_W-1:0] block_addr_i,
  input  wire logic              done_o,
  input  wire logic [1:0]        status_o,
  input  wire logic [ADDR_W-1:0] alloc_addr_o,
  output int                     fail_count,
  output int                     pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIVE_CLASSES = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;

  typedef struct packed {
    scba_status_e      status;
    logic [ADDR_W-1:0] addr;
  } grant_t;

  grant_t            grant_q[$];
  logic [IDX_W-1:0]  idx_stack_img [MAX_CLASSES][MAX_BLOCKS];
  int unsigned       free_level [MAX_CLASSES];
  int unsigned       blk_bytes  [MAX_CLASSES];
  int unsigned       blk_limit  [MAX_CLASSES];
  int                mismatches;

  function automatic int unsigned pool_depth(int unsigned bytes);
    if (bytes <= 32) return 1024;
    if (bytes <= 128) return 512;
    if (bytes <= 512) return 256;
    return 128;
  endfunction

  task automatic fill_pools();
    int unsigned b;
    int unsigned n;
    for (int unsigned c = 0; c < MAX_CLASSES; c++) begin
      blk_bytes[c]  = 0;
      blk_limit[c]  = 0;
      free_level[c] = 0;
      for (int unsigned i = 0; i < MAX_BLOCKS; i++) idx_stack_img[c][i] = '0;
    end
    for (int unsigned c = 0; c < LIVE_CLASSES; c++) begin
      b = 8 << c;
      blk_bytes[c] = ((b % MIN_ALIGN) != 0) ? b + (MIN_ALIGN - (b % MIN_ALIGN)) : b;
      n = pool_depth(b);
      if (n > OFFSET_SPAN / blk_bytes[c]) n = OFFSET_SPAN / blk_bytes[c];
      blk_limit[c]  = n;
      free_level[c] = n;
      for (int unsigned i = 0; i < n; i++) idx_stack_img[c][i] = IDX_W'(i);
    end
  endtask

  // Works out the grant for one accepted request and updates the pools.
  task automatic serve_request(input logic op, input logic [SIZE_W-1:0] sz,
                               input logic [ADDR_W-1:0] addr);
    grant_t      g;
    int unsigned c;
    int unsigned off;
    bit          found;
    g.status = ST_OK;
    g.addr   = '0;
    found    = 1'b0;
    if (op == OP_ALLOC) begin
      c = 0;
      if (sz == 0) begin
        g.status = ST_INVAL;
      end else begin
        for (int unsigned k = 0; k < LIVE_CLASSES; k++) begin
          if (!found && sz <= (8 << k)) begin
            found = 1'b1;
            c = k;
          end
        end
        if (!found) begin
          g.status = ST_INVAL;
        end else if (free_level[c] == 0) begin
          g.status = ST_NOMEM;
        end else begin
          free_level[c]--;
          g.addr = ADDR_W'((c << OFFSET_BITS) |
                   (idx_stack_img[c][free_level[c] % MAX_BLOCKS] * blk_bytes[c]));
        end
      end
    end else begin
      c   = addr >> OFFSET_BITS;
      off = addr % OFFSET_SPAN;
      if (c >= LIVE_CLASSES) begin
        g.status = ST_INVAL;
      end else if (blk_bytes[c] == 0 || off >= blk_bytes[c] * blk_limit[c]) begin
        g.status = ST_INVAL;
      end else if (off % blk_bytes[c] != 0) begin
        g.status = ST_INVAL;
      end else if (free_level[c] >= blk_limit[c]) begin
        g.status = ST_STATE;
      end else begin
        idx_stack_img[c][free_level[c] % MAX_BLOCKS] = IDX_W'(off / blk_bytes[c]);
        free_level[c]++;
      end
    end
    grant_q.push_back(g);
  endtask

  task automatic check_result(input logic [1:0] st, input logic [ADDR_W-1:0] addr);
    grant_t g;
    if (grant_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result, status %0d addr %h", $realtime, st, addr);
    end else begin
      g = grant_q.pop_front();
      if (st !== g.status || addr !== g.addr) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, expected status %0d addr %h, got status %0d addr %h",
                   $realtime, g.status, g.addr, st, addr);
      end
    end
  endtask

  initial mismatches = 0;

  // Results are compared before the request of the same edge is predicted; a result can
  // never belong to a request accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_pools();
      grant_q.delete();
      pending <= 0;
    end else begin
      if (done_o) check_result(status_o, alloc_addr_o);
      if (start && !busy) serve_request(op_i, req_size_i, block_addr_i);
      pending <= grant_q.size();
    end
    fail_count <= mismatches;
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Top of the size class block allocator bench: clock, reset, request stimulus and verdict.
`default_nettype none

module testbench import scba_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Number of request beats, the directed ones included, after which stimulus stops.
  localparam int unsigned TOTAL_BEATS = 1520;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              op_i         = OP_ALLOC;
  logic [SIZE_W-1:0] req_size_i   = '0;
  logic [ADDR_W-1:0] block_addr_i = '0;
  logic              busy;
  logic              done_o;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] alloc_addr_o;
  int                fail_count;
  int                pending;

  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;

  size_class_block_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .req_size_i   (req_size_i),
    .block_addr_i (block_addr_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .alloc_addr_o (alloc_addr_o)
  );

  allocator_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .req_size_i   (req_size_i),
    .block_addr_i (block_addr_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .alloc_addr_o (alloc_addr_o),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Geometry of the default build, used only to place frees against real block boundaries.
  function automatic int unsigned block_bytes(int unsigned c);
    int unsigned b;
    b = 8 << c;
    if (b % MIN_ALIGN_DEF != 0) b = b + (MIN_ALIGN_DEF - (b % MIN_ALIGN_DEF));
    return b;
  endfunction

  function automatic int unsigned blocks_in_pool(int unsigned c);
    int unsigned b;
    b = 8 << c;
    if (b <= 32) return 1024;
    if (b <= 128) return 512;
    if (b <= 512) return 256;
    return 128;
  endfunction

  // The classes with 128 blocks are the ones that a run of allocations can drain, so
  // at least half of the runs go to them.
  function automatic int unsigned pick_class();
    if ($urandom_range(0, 1) == 1) return $urandom_range(7, 9);
    return $urandom_range(0, 9);
  endfunction

  // A request size that lands in class c: one byte above the class below, up to its size.
  function automatic logic [SIZE_W-1:0] size_in_class(int unsigned c);
    int unsigned lo;
    lo = (c == 0) ? 1 : (8 << (c - 1)) + 1;
    return SIZE_W'($urandom_range(lo, 8 << c));
  endfunction

  function automatic logic [ADDR_W-1:0] block_at(int unsigned c, int unsigned off);
    return ADDR_W'((c << OFFSET_BITS) | off);
  endfunction

  // Presents one request beat and waits for the edge that accepts it. After the last
  // beat of a burst the start line drops for a random gap; a gap of zero keeps start
  // high so that the next beat is presented without a break.
  task automatic issue(input logic op, input logic [SIZE_W-1:0] sz,
                       input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    op_i         <= op;
    req_size_i   <= sz;
    block_addr_i <= addr;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    beats_sent++;
    if (beats_sent >= TOTAL_BEATS) begin
      start <= 1'b0;
    end else if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic alloc_run(int unsigned c);
    int unsigned len;
    len = (c >= 7) ? $urandom_range(1, 150) : $urandom_range(1, 60);
    for (int unsigned k = 0; k < len && beats_sent < TOTAL_BEATS; k++)
      issue(OP_ALLOC, size_in_class(c), ADDR_W'($urandom));
  endtask

  // Frees aimed at real block boundaries of one class. Blocks that were never handed
  // out are freed too, which the block cannot tell apart from a genuine free.
  task automatic free_run(int unsigned c);
    int unsigned len;
    int unsigned idx;
    len = $urandom_range(1, 60);
    for (int unsigned k = 0; k < len && beats_sent < TOTAL_BEATS; k++) begin
      idx = $urandom_range(0, blocks_in_pool(c) - 1);
      issue(OP_FREE, SIZE_W'($urandom), block_at(c, idx * block_bytes(c)));
    end
  endtask

  // Frees that must be refused, with a bad class, outside the pool or off a block
  // boundary, or at plain random addresses, which may still be accepted.
  task automatic broken_free();
    int unsigned c;
    int unsigned bsz;
    logic [ADDR_W-1:0] addr;
    c   = $urandom_range(0, 8);
    bsz = block_bytes(c);
    case ($urandom_range(0, 3))
      0: addr = block_at($urandom_range(10, 15), $urandom_range(0, OFFSET_SPAN - 1));
      1: addr = block_at(c, $urandom_range(bsz * blocks_in_pool(c), OFFSET_SPAN - 1));
      2: addr = block_at(c, $urandom_range(0, blocks_in_pool(c) - 1) * bsz +
                            $urandom_range(1, bsz - 1));
      default: addr = ADDR_W'($urandom);
    endcase
    issue(OP_FREE, SIZE_W'($urandom), addr);
  endtask

  initial begin
    int unsigned guard;
    int unsigned c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats: size extremes, class boundaries and every refusal of a free.
    issue(OP_ALLOC, 32'd0, '0);                       // zero size
    issue(OP_ALLOC, 32'd1, '0);
    issue(OP_ALLOC, 32'd8, '0);
    issue(OP_ALLOC, 32'd9, ADDR_W'({ADDR_W{1'b1}}));
    issue(OP_ALLOC, 32'd4096, '0);                    // largest class, takes block 127
    issue(OP_ALLOC, 32'd4097, '0);                    // oversize
    issue(OP_ALLOC, 32'hFFFF_FFFF, '0);
    issue(OP_ALLOC, 32'h8000_0000, '0);
    issue(OP_FREE, 32'hFFFF_FFFF, '0);                // address zero is a real block
    issue(OP_FREE, '0, 23'h7F_FFFF);                  // class code out of range
    issue(OP_FREE, '0, block_at(10, 0));
    issue(OP_FREE, '0, block_at(0, 16384));           // just past the pool span
    issue(OP_FREE, '0, block_at(9, 8));               // off a block boundary
    issue(OP_FREE, '0, block_at(5, 0));               // pool already full
    issue(OP_FREE, '0, block_at(9, 127 * 4096));      // returns the block taken above
    issue(OP_FREE, '0, block_at(9, 127 * 4096));      // now full again
    issue(OP_ALLOC, 32'd2048, '0);
    issue(OP_ALLOC, 32'd513, '0);
    issue(OP_ALLOC, 32'd65, '0);
    issue(OP_FREE, '0, block_at(4, 511 * 128));

    // Random part: mostly runs that drain and refill pools, with some noise mixed in.
    while (beats_sent < TOTAL_BEATS) begin
      c = pick_class();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: alloc_run(c);
        4, 5, 6:    free_run(c);
        7:          broken_free();
        8:          issue(OP_ALLOC, ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom),
                          ADDR_W'($urandom));
        default:    issue(logic'($urandom_range(0, 1)), SIZE_W'($urandom), ADDR_W'($urandom));
      endcase
    end

    // Drain: wait for every predicted result, then keep running so that a stray
    // extra result would still be caught.
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending != 0) begin
      $display("Some tests failed");
    end else begin
      repeat (12) @(posedge clk_i);
      if (fail_count == 0 && pending == 0)
        $display("All tests passed");
      else
        $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/scba_pkg.sv
rtl/core/scba_front.sv
rtl/core/scba_queue.sv
rtl/core/scba_back.sv
rtl/core/size_class_block_allocator.sv
bench/allocator_checker.sv
bench/testbench.sv
